/* design/tsm_pkg.sv */
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants of the track slot manager
// Field widths, command codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int SENSOR_W   = 2;
  localparam int PRIO_W     = 16;
  localparam int ID_W       = 5;
  localparam int LIFE_W     = 16;
  localparam int LOST_W     = 8;
  localparam int COAST_W    = 8;
  localparam int CONFIRM_W  = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // id space is searched a chunk of eight ids per cycle
  localparam int ID_SPACE  = 32;
  localparam int ID_CHUNK  = 8;
  localparam int ID_CHUNKS = ID_SPACE / ID_CHUNK;
  localparam int CHUNK_W   = $clog2(ID_CHUNKS);
  localparam int POS_W     = $clog2(ID_CHUNK);

  localparam logic [LIFE_W-1:0] LIFE_WRAP = LIFE_W'(65534);
  localparam logic [LOST_W-1:0] LOST_WRAP = LOST_W'(254);

  localparam logic [COAST_W-1:0]   COAST_RESET   = COAST_W'(3);
  localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = CONFIRM_W'(3);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COAST_LIMIT      = 2'd0,
    CFG_CONFIRM_LIFETIME = 2'd1,
    CFG_SPARE_2          = 2'd2,
    CFG_SPARE_3          = 2'd3
  } cfg_index_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE    = 2'd0,
    CMD_MARK_SEEN = 2'd1,
    CMD_MAINTAIN  = 2'd2,
    CMD_NOP       = 2'd3
  } command_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_ID_SEARCH,
    ST_CREATE_WR,
    ST_READ,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic id_step;
    logic create_wr;
    logic slot_rd;
    logic slot_upd;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic take;
    logic id_hit;
    logic id_last;
    logic out_free;
  } dp_status_t;

  // ids that may be handed out: 1 up to top-1
  function automatic logic [ID_SPACE-1:0] usable_ids(input int top);
    logic [ID_SPACE-1:0] m;
    for (int i = 0; i < ID_SPACE; i++) begin
      m[i] = (i >= 1) && (i < top);
    end
    return m;
  endfunction

endpackage

/* design/tsm_if.sv */
// ----------------------------------------------------------------------------
// tsm_if: channel interfaces of the track slot manager
// Request, response and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface tsm_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsm_pkg::CMD_W-1:0]     command;
  logic [tsm_pkg::SLOT_W-1:0]    slot;
  logic [tsm_pkg::SENSOR_W-1:0]  sensor;
  logic [tsm_pkg::PRIO_W-1:0]    new_priority;

  modport source (output valid, command, slot, sensor, new_priority, input ready);
  modport sink   (input valid, command, slot, sensor, new_priority, output ready);
endinterface

interface tsm_out_if;
  logic                         valid;
  logic                         ready;
  logic [tsm_pkg::SLOT_W-1:0]   slot_used;
  logic [tsm_pkg::ID_W-1:0]     track_id;
  logic                         created;
  logic                         dropped;
  logic                         confirmed;
  logic [tsm_pkg::LOST_W-1:0]   lost_cycles;

  modport source (output valid, slot_used, track_id, created, dropped, confirmed,
                  lost_cycles, input ready);
  modport sink   (input valid, slot_used, track_id, created, dropped, confirmed,
                  lost_cycles, output ready);
endinterface

interface tsm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tsm_pkg::CFG_INDEX_W-1:0]   index;
  logic [tsm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/track_slot_manager_core.sv */
// ----------------------------------------------------------------------------
// track_slot_manager_core: table of tracked-object slots with coasting
// Top level: joins the sequencer and the datapath to the channel interfaces.
// ----------------------------------------------------------------------------
// One request is handled at a time. Create scans the slot memory through its
// single read port, one slot per cycle, then searches the id space eight ids
// per cycle; a refused create instead reports the addressed slot. Mark_seen
// and maintain are a read-modify-write of one slot; no-op reads and reports
// one slot without writing it. A finished result sits in an output register,
// so the next request is accepted while it waits. Reset frees all slots at
// once through per-slot valid bits; no clearing pass.
module track_slot_manager_core #(
  parameter int SLOT_COUNT   = 16,
  parameter int SENSOR_COUNT = 4,
  parameter int ID_LIMIT     = 32
) (
  input  logic       clk,
  input  logic       rst,
  tsm_in_if.sink     req,
  tsm_out_if.source  rsp,
  tsm_cfg_if.sink    cfg
);
  import tsm_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  assign req.ready = in_ready;

  tsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (in_ready),
    .in_command (command_t'(req.command)),
    .status     (status),
    .cmd        (cmd)
  );

  tsm_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SENSOR_COUNT (SENSOR_COUNT),
    .ID_LIMIT     (ID_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_command  (req.command),
    .in_slot     (req.slot),
    .in_sensor   (req.sensor),
    .in_priority (req.new_priority),
    .rsp         (rsp),
    .cfg         (cfg)
  );

endmodule

/* design/tsm_ctrl.sv */
// ----------------------------------------------------------------------------
// tsm_ctrl: sequencer of the track slot manager
// Walks one request through scan, id search, read-modify-write and response.
// ----------------------------------------------------------------------------
module tsm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsm_pkg::command_t   in_command,
  input  tsm_pkg::dp_status_t status,
  output tsm_pkg::ctl_cmd_t   cmd
);
  import tsm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_command == CMD_CREATE) ? ST_SCAN : ST_READ;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_next = ST_DECIDE;
      ST_DECIDE: begin
        // refused create falls back to reporting the addressed slot
        state_next = status.take ? ST_ID_SEARCH : ST_READ;
      end
      ST_ID_SEARCH: begin
        if (status.id_hit || status.id_last) begin
          state_next = ST_CREATE_WR;
        end
      end
      ST_CREATE_WR: state_next = ST_FINISH;
      ST_READ:      state_next = ST_UPDATE;
      ST_UPDATE:    state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:      cmd.scan_rd   = 1'b1;
      ST_ID_SEARCH: cmd.id_step   = 1'b1;
      ST_CREATE_WR: cmd.create_wr = 1'b1;
      ST_READ:      cmd.slot_rd   = 1'b1;
      ST_UPDATE:    cmd.slot_upd  = 1'b1;
      ST_FINISH:    cmd.out_load  = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* design/tsm_datapath.sv */
// ----------------------------------------------------------------------------
// tsm_datapath: slot table, search logic and result register
// Holds the slot memory, configuration, scan and id-search registers, and
// the response register that drives the output channel.
// ----------------------------------------------------------------------------
module tsm_datapath #(
  parameter int SLOT_COUNT   = 16,
  parameter int SENSOR_COUNT = 4,
  parameter int ID_LIMIT     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tsm_pkg::ctl_cmd_t                 cmd,
  output tsm_pkg::dp_status_t               status,
  input  logic [tsm_pkg::CMD_W-1:0]         in_command,
  input  logic [tsm_pkg::SLOT_W-1:0]        in_slot,
  input  logic [tsm_pkg::SENSOR_W-1:0]      in_sensor,
  input  logic [tsm_pkg::PRIO_W-1:0]        in_priority,
  tsm_out_if.source                         rsp,
  tsm_cfg_if.sink                           cfg
);
  import tsm_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int ID_TOP = (ID_LIMIT < ID_SPACE) ? ID_LIMIT : ID_SPACE;
  localparam logic [IDX_W-1:0]    LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CHUNK_W-1:0]  LAST_CHUNK = CHUNK_W'(ID_CHUNKS - 1);
  localparam logic [ID_SPACE-1:0] ID_USABLE = usable_ids(ID_TOP);

  typedef struct packed {
    logic [ID_W-1:0]         track_id;
    logic [PRIO_W-1:0]       priority_v;
    logic [LIFE_W-1:0]       lifetime;
    logic [LOST_W-1:0]       lost;
    logic [SENSOR_COUNT-1:0] seen;
  } entry_t;

  // configuration
  logic [COAST_W-1:0]   coast_limit;
  logic [CONFIRM_W-1:0] confirm_lifetime;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coast_limit      <= COAST_RESET;
      confirm_lifetime <= CONFIRM_RESET;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_COAST_LIMIT:      coast_limit      <= cfg.data[COAST_W-1:0];
        CFG_CONFIRM_LIFETIME: confirm_lifetime <= cfg.data[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  // latched request
  command_t            cmd_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SENSOR_W-1:0] sensor_q;
  logic [PRIO_W-1:0]   prio_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q    <= command_t'(in_command);
      slot_q   <= in_slot;
      sensor_q <= in_sensor;
      prio_q   <= in_priority;
    end
  end

  logic [IDX_W-1:0] slot_ix;
  logic             slot_in_range;
  assign slot_ix       = IDX_W'(slot_q);
  assign slot_in_range = 32'(slot_q) < SLOT_COUNT;

  // slot memory; entries that were never written since reset read as zero
  entry_t           mem [SLOT_COUNT];
  logic             vld [SLOT_COUNT];
  entry_t           rd_q;
  logic             rd_vld_q;
  entry_t           rd_ent;
  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic             wr_en;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] scan_cnt;

  assign rd_en  = cmd.scan_rd || cmd.slot_rd;
  assign raddr  = cmd.scan_rd ? scan_cnt : slot_ix;
  assign rd_ent = rd_vld_q ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[raddr];
      rd_vld_q <= vld[raddr];
    end
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vld[waddr] <= 1'b1;
    end
  end

  // create scan: first free slot, else first slot of lowest priority
  logic                scan_v;
  logic [IDX_W-1:0]    scan_idx;
  logic                have_free;
  logic [PRIO_W:0]     worst;
  logic [ID_W-1:0]     worst_id;
  logic [IDX_W-1:0]    pick;
  logic [ID_SPACE-1:0] id_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v <= 1'b0;
    end else begin
      scan_v <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_cnt;
    if (cmd.load) begin
      scan_cnt  <= '0;
      have_free <= 1'b0;
      worst     <= {1'b1, {PRIO_W{1'b0}}};
      worst_id  <= '0;
      pick      <= '0;
      id_map    <= '0;
    end else begin
      if (cmd.scan_rd) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (scan_v) begin
        if (!have_free) begin
          if (rd_ent.track_id == '0) begin
            have_free <= 1'b1;
            pick      <= scan_idx;
          end else if ({1'b0, rd_ent.priority_v} < worst) begin
            worst    <= {1'b0, rd_ent.priority_v};
            worst_id <= rd_ent.track_id;
            pick     <= scan_idx;
          end
        end
        if (rd_ent.track_id != '0) begin
          id_map[rd_ent.track_id] <= 1'b1;
        end
      end
    end
  end

  // id search; a replaced slot's id is freed before the search
  logic [ID_SPACE-1:0] drop_mask;
  logic [ID_SPACE-1:0] avail;
  logic [CHUNK_W-1:0]  chunk;
  logic [ID_CHUNK-1:0] chunk_bits;
  logic [POS_W-1:0]    chunk_pos;
  logic [ID_W-1:0]     new_id;

  assign drop_mask  = have_free ? '0 : (ID_SPACE'(1) << worst_id);
  assign avail      = ~(id_map & ~drop_mask) & ID_USABLE;
  assign chunk_bits = avail[chunk*ID_CHUNK +: ID_CHUNK];

  always_comb begin
    chunk_pos = '0;
    for (int j = ID_CHUNK - 1; j >= 0; j--) begin
      if (chunk_bits[j]) begin
        chunk_pos = POS_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chunk  <= '0;
      new_id <= '0;
    end else if (cmd.id_step) begin
      chunk <= chunk + 1'b1;
      if (|chunk_bits) begin
        new_id <= {chunk, chunk_pos};
      end
    end
  end

  // slot update for mark_seen, maintain and plain report
  entry_t                  upd;
  logic                    upd_wr;
  logic                    upd_drop;
  logic [LIFE_W-1:0]       life_n;
  logic [LOST_W-1:0]       lost_n;
  logic [SENSOR_COUNT-1:0] sens_bit;
  logic                    sens_in_range;

  assign life_n        = (rd_ent.lifetime == LIFE_WRAP) ? '0 : rd_ent.lifetime + 1'b1;
  assign lost_n        = (rd_ent.lost == LOST_WRAP) ? '0 : rd_ent.lost + 1'b1;
  assign sens_bit      = SENSOR_COUNT'(1) << sensor_q;
  assign sens_in_range = 32'(sensor_q) < SENSOR_COUNT;

  always_comb begin
    upd      = rd_ent;
    upd_wr   = 1'b0;
    upd_drop = 1'b0;
    case (cmd_q)
      CMD_MARK_SEEN: begin
        upd_wr = 1'b1;
        if (sens_in_range) begin
          upd.seen = rd_ent.seen | sens_bit;
        end
      end
      CMD_MAINTAIN: begin
        upd_wr        = 1'b1;
        upd.lifetime  = life_n;
        // the first maintain after creation does not count as lost
        if (life_n > LIFE_W'(1)) begin
          if (rd_ent.seen == '0) begin
            upd.lost = lost_n;
          end else begin
            upd.lost = '0;
          end
        end
        upd.seen = '0;
        if ((life_n > LIFE_W'(1)) && (rd_ent.seen == '0) && (lost_n > coast_limit)) begin
          upd_drop = rd_ent.track_id != '0;
          upd      = '0;
        end
      end
      default: begin
        upd_wr = 1'b0;
      end
    endcase
    if (!slot_in_range) begin
      upd      = '0;
      upd_wr   = 1'b0;
      upd_drop = 1'b0;
    end
  end

  entry_t new_ent;
  always_comb begin
    new_ent            = '0;
    new_ent.track_id   = new_id;
    new_ent.priority_v = prio_q;
  end

  assign wr_en = cmd.create_wr || (cmd.slot_upd && upd_wr);
  assign waddr = cmd.create_wr ? pick : slot_ix;
  assign wdata = cmd.create_wr ? new_ent : upd;

  // result staging
  entry_t            res_ent;
  logic [SLOT_W-1:0] rep_slot;
  logic              created_q;
  logic              dropped_q;

  always_ff @(posedge clk) begin
    if (cmd.create_wr) begin
      res_ent   <= new_ent;
      rep_slot  <= SLOT_W'(pick);
      created_q <= 1'b1;
      dropped_q <= 1'b0;
    end else if (cmd.slot_upd) begin
      res_ent   <= upd;
      rep_slot  <= slot_q;
      created_q <= 1'b0;
      dropped_q <= upd_drop;
    end
  end

  // response register
  logic rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.slot_used   <= rep_slot;
      rsp.track_id    <= res_ent.track_id;
      rsp.created     <= created_q;
      rsp.dropped     <= dropped_q;
      rsp.confirmed   <= (res_ent.track_id != '0) && (res_ent.lifetime >= confirm_lifetime);
      rsp.lost_cycles <= res_ent.lost;
    end
  end

  assign rsp.valid = rsp_valid;

  assign status.scan_last = scan_cnt == LAST_SLOT;
  assign status.take      = have_free || ({1'b0, prio_q} > worst);
  assign status.id_hit    = |chunk_bits;
  assign status.id_last   = chunk == LAST_CHUNK;
  assign status.out_free  = !rsp_valid || rsp.ready;

endmodule
